>>> rtl/core/grid_segment_free_check_macros.svh
// Assertion macros for the checker file
`ifndef GRID_SEGMENT_FREE_CHECK_MACROS_SVH
`define GRID_SEGMENT_FREE_CHECK_MACROS_SVH

// Same-cycle implication
`define GSFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gsfc port check failed");

// Next-cycle implication
`define GSFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gsfc port check failed");

`endif

>>> rtl/core/gsfc_pkg.sv
`timescale 1ns / 1ps
package gsfc_pkg;

  localparam int NUM_SLOTS      = 4;
  localparam int SLOT_W         = 2;
  localparam int CELL_AW        = 16;
  localparam int CELLS_PER_SLOT = 65536;
  localparam int MEM_DEPTH      = NUM_SLOTS * CELLS_PER_SLOT;
  localparam int FRAC_BITS      = 8;
  localparam int ROOT_STEPS     = 25;
  localparam int DIV_STEPS      = 9;

  localparam logic [6:0] THRESH_RESET = 7'd64;
  localparam logic [7:0] VAL_UNOBSERVED = 8'hFF;

  // Operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_GEOM  = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  // Outcome codes
  localparam logic [1:0] OUT_FREE    = 2'd0;
  localparam logic [1:0] OUT_OCC     = 2'd1;
  localparam logic [1:0] OUT_UNKNOWN = 2'd2;
  localparam logic [1:0] OUT_ACK     = 2'd3;

  // Probe answers
  localparam logic [1:0] ANS_NONE    = 2'd0;
  localparam logic [1:0] ANS_FREE    = 2'd1;
  localparam logic [1:0] ANS_BLOCKED = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       write_cell;
    logic       write_geom;
    logic       ack;
    logic       square;
    logic       sum_sq;
    logic       root_step;
    logic       div_load;
    logic       div_axis;
    logic       div_step;
    logic       div_store;
    logic       walk_init;
    logic       walk_next;
    logic       second;
    logic       probe_rel;
    logic       probe_cell;
    logic       probe_addr;
    logic       probe_read;
    logic       finish;
    logic [1:0] finish_code;
  } cmd_t;

  typedef struct packed {
    logic       last_sample;
    logic       use_second;
    logic [1:0] answer;
  } stat_t;

endpackage

>>> rtl/core/gsfc_ctrl.sv
`timescale 1ns / 1ps
module gsfc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     operation,
  input  gsfc_pkg::stat_t stat,
  output gsfc_pkg::cmd_t  cmd,
  output logic           busy
);
  import gsfc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQUARE = 4'd1;
  localparam logic [3:0] S_SUM    = 4'd2;
  localparam logic [3:0] S_ROOT   = 4'd3;
  localparam logic [3:0] S_DLOAD  = 4'd4;
  localparam logic [3:0] S_DSTEP  = 4'd5;
  localparam logic [3:0] S_DSTORE = 4'd6;
  localparam logic [3:0] S_WINIT  = 4'd7;
  localparam logic [3:0] S_PREL   = 4'd8;
  localparam logic [3:0] S_PCELL  = 4'd9;
  localparam logic [3:0] S_PADDR  = 4'd10;
  localparam logic [3:0] S_PREAD  = 4'd11;
  localparam logic [3:0] S_PEVAL  = 4'd12;

  logic [3:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       axis, axis_next;
  logic       second, second_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Sequence one item
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    axis_next   = axis;
    second_next = second;
    cmd         = '0;
    cmd.div_axis = axis;
    cmd.second   = second;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture    = 1'b1;
          cmd.write_cell = (operation == OP_LOAD);
          cmd.write_geom = (operation == OP_GEOM);
          cmd.ack        = (operation != OP_CHECK);
          if (operation == OP_CHECK) state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_sq = 1'b1;
        cnt_next   = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + 5'd1;
        if (cnt == 5'(ROOT_STEPS - 1)) begin
          axis_next  = 1'b0;
          state_next = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS - 1)) state_next = S_DSTORE;
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_DLOAD;
        end else begin
          state_next = S_WINIT;
        end
      end
      S_WINIT: begin
        cmd.walk_init = 1'b1;
        second_next   = 1'b0;
        state_next    = S_PREL;
      end
      S_PREL: begin
        cmd.probe_rel = 1'b1;
        state_next    = S_PCELL;
      end
      S_PCELL: begin
        cmd.probe_cell = 1'b1;
        state_next     = S_PADDR;
      end
      S_PADDR: begin
        cmd.probe_addr = 1'b1;
        state_next     = S_PREAD;
      end
      S_PREAD: begin
        cmd.probe_read = 1'b1;
        state_next     = S_PEVAL;
      end
      S_PEVAL: begin
        // decide on this sample, go on to the next sample or try the second slot
        if (stat.answer == ANS_FREE) begin
          if (stat.last_sample) begin
            cmd.finish      = 1'b1;
            cmd.finish_code = OUT_FREE;
            state_next      = S_IDLE;
          end else begin
            cmd.walk_next = 1'b1;
            second_next   = 1'b0;
            state_next    = S_PREL;
          end
        end else if (stat.answer == ANS_BLOCKED) begin
          cmd.finish      = 1'b1;
          cmd.finish_code = OUT_OCC;
          state_next      = S_IDLE;
        end else if (stat.use_second && !second) begin
          second_next = 1'b1;
          state_next  = S_PREL;
        end else begin
          cmd.finish      = 1'b1;
          cmd.finish_code = OUT_UNKNOWN;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      axis   <= 1'b0;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      axis   <= axis_next;
      second <= second_next;
    end
  end

endmodule

>>> rtl/core/gsfc_dp.sv
`timescale 1ns / 1ps
module gsfc_dp (
  input  logic                clk,
  input  logic                rst,
  input  gsfc_pkg::cmd_t      cmd,
  output gsfc_pkg::stat_t     stat,
  input  logic [1:0]          slot,
  input  logic [1:0]          second_slot,
  input  logic                use_second,
  input  logic [15:0]         cell_index,
  input  logic signed [7:0]   cell_value,
  input  logic signed [23:0]  point_a_x,
  input  logic signed [23:0]  point_a_y,
  input  logic signed [23:0]  point_b_x,
  input  logic signed [23:0]  point_b_y,
  input  logic [10:0]         grid_width,
  input  logic [10:0]         grid_height,
  input  logic                cfg_wr,
  input  logic [6:0]          cfg_data,
  output logic                result_valid,
  output logic                path_free,
  output logic [1:0]          outcome,
  output logic [16:0]         samples_checked
);
  import gsfc_pkg::*;

  // cell memory and slot geometry
  logic [7:0]         cell_mem [0:MEM_DEPTH-1];
  logic [NUM_SLOTS-1:0] slot_valid;
  logic signed [23:0] slot_ox [0:NUM_SLOTS-1];
  logic signed [23:0] slot_oy [0:NUM_SLOTS-1];
  logic [10:0]        slot_w  [0:NUM_SLOTS-1];
  logic [10:0]        slot_h  [0:NUM_SLOTS-1];
  logic [6:0]         thresh;

  // captured check operands
  logic signed [23:0] ax, ay;
  logic [24:0]        magx, magy;
  logic               negx, negy;
  logic [1:0]         s1, s2;
  logic               use2;
  logic signed [24:0] dxw, dyw;

  // length
  logic [49:0] sqx, sqy, root_s, root_res, root_bit;
  logic [50:0] root_trial;
  logic [24:0] rlen;
  logic [16:0] nlast;

  // division
  logic [32:0] div_rem, div_d;
  logic [8:0]  div_q;
  logic [33:0] div_trial;
  logic [8:0]  qstep_x, qstep_y;
  logic [24:0] rstep_x, rstep_y;

  // walk
  logic [16:0] k;
  logic [24:0] qx, qy, remx, remy;
  logic [25:0] sumx, sumy;

  // probe pipeline
  logic [1:0]         ps;
  logic signed [26:0] relx, rely;
  logic               slot_ok;
  logic [18:0]        cxw, cyw;
  logic               okx, oky;
  logic [10:0]        cx, cy, pw;
  logic               cell_ok;
  logic [21:0]        addr;
  logic               read_ok;
  logic [7:0]         rdata;

  assign dxw = {point_b_x[23], point_b_x} - {point_a_x[23], point_a_x};
  assign dyw = {point_b_y[23], point_b_y} - {point_a_y[23], point_a_y};

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) thresh <= THRESH_RESET;
    else if (cfg_wr) thresh <= cfg_data;
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.write_cell) cell_mem[{slot, cell_index}] <= cell_value;
    if (cmd.probe_read) rdata <= cell_mem[{ps, addr[CELL_AW-1:0]}];
  end

  // slot geometry
  always_ff @(posedge clk) begin
    if (rst) slot_valid <= '0;
    else if (cmd.write_geom) slot_valid[slot] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.write_geom) begin
      slot_ox[slot] <= point_a_x;
      slot_oy[slot] <= point_a_y;
      slot_w[slot]  <= grid_width;
      slot_h[slot]  <= grid_height;
    end
  end

  // capture operands of a check
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ax   <= point_a_x;
      ay   <= point_a_y;
      negx <= dxw[24];
      negy <= dyw[24];
      magx <= dxw[24] ? 25'(-dxw) : 25'(dxw);
      magy <= dyw[24] ? 25'(-dyw) : 25'(dyw);
      s1   <= slot;
      s2   <= second_slot;
      use2 <= use_second;
    end
  end

  // squares, then bit-pair square root
  assign root_trial = {1'b0, root_res} + {1'b0, root_bit};

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sqx <= {25'd0, magx} * {25'd0, magx};
      sqy <= {25'd0, magy} * {25'd0, magy};
    end
    if (cmd.sum_sq) begin
      root_s   <= sqx + sqy;
      root_res <= '0;
      root_bit <= 50'd1 << 48;
    end else if (cmd.root_step) begin
      if ({1'b0, root_s} >= root_trial) begin
        root_s   <= 50'({1'b0, root_s} - root_trial);
        root_res <= (root_res >> 1) + root_bit;
      end else begin
        root_res <= root_res >> 1;
      end
      root_bit <= root_bit >> 2;
    end
  end

  assign rlen  = root_res[24:0];
  assign nlast = rlen[24:FRAC_BITS];

  // restoring division of the scaled magnitude by the length
  assign div_trial = {1'b0, div_rem} - {1'b0, div_d};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_rem <= {(cmd.div_axis ? magy : magx), 8'd0};
      div_d   <= {rlen, 8'd0};
      div_q   <= '0;
    end else if (cmd.div_step) begin
      if (!div_trial[33]) div_rem <= div_trial[32:0];
      div_q <= {div_q[7:0], !div_trial[33]};
      div_d <= div_d >> 1;
    end
    if (cmd.div_store) begin
      if (cmd.div_axis) begin
        qstep_y <= div_q;
        rstep_y <= div_rem[24:0];
      end else begin
        qstep_x <= div_q;
        rstep_x <= div_rem[24:0];
      end
    end
  end

  // advance the sample point by the stored quotient and remainder
  assign sumx = {1'b0, remx} + {1'b0, rstep_x};
  assign sumy = {1'b0, remy} + {1'b0, rstep_y};

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      k    <= '0;
      qx   <= '0;
      qy   <= '0;
      remx <= '0;
      remy <= '0;
    end else if (cmd.walk_next) begin
      k <= k + 17'd1;
      if (sumx >= {1'b0, rlen}) begin
        remx <= 25'(sumx - {1'b0, rlen});
        qx   <= qx + {16'd0, qstep_x} + 25'd1;
      end else begin
        remx <= sumx[24:0];
        qx   <= qx + {16'd0, qstep_x};
      end
      if (sumy >= {1'b0, rlen}) begin
        remy <= 25'(sumy - {1'b0, rlen});
        qy   <= qy + {16'd0, qstep_y} + 25'd1;
      end else begin
        remy <= sumy[24:0];
        qy   <= qy + {16'd0, qstep_y};
      end
    end
  end

  // cell coordinates truncated toward zero
  assign cxw = relx[26] ? 19'd0 : 19'(relx[26:FRAC_BITS]);
  assign cyw = rely[26] ? 19'd0 : 19'(rely[26:FRAC_BITS]);
  assign okx = !relx[26] || (relx > -27'sd256);
  assign oky = !rely[26] || (rely > -27'sd256);

  // probe pipeline: relative position, cell, address, read
  always_ff @(posedge clk) begin
    if (cmd.probe_rel) begin
      ps      <= cmd.second ? s2 : s1;
      slot_ok <= slot_valid[cmd.second ? s2 : s1];
      relx <= {{3{ax[23]}}, ax}
            + (negx ? -$signed({2'b00, qx}) : $signed({2'b00, qx}))
            - {{3{slot_ox[cmd.second ? s2 : s1][23]}}, slot_ox[cmd.second ? s2 : s1]};
      rely <= {{3{ay[23]}}, ay}
            + (negy ? -$signed({2'b00, qy}) : $signed({2'b00, qy}))
            - {{3{slot_oy[cmd.second ? s2 : s1][23]}}, slot_oy[cmd.second ? s2 : s1]};
    end
    if (cmd.probe_cell) begin
      cx      <= cxw[10:0];
      cy      <= cyw[10:0];
      pw      <= slot_w[ps];
      cell_ok <= slot_ok && okx && oky && (cxw < {8'd0, slot_w[ps]})
                 && (cyw < {8'd0, slot_h[ps]});
    end
    if (cmd.probe_addr) begin
      addr <= 22'({11'd0, cy} * {11'd0, pw}) + {11'd0, cx};
    end
    if (cmd.probe_read) begin
      read_ok <= cell_ok && (addr[21:CELL_AW] == '0);
    end
  end

  // answer of the current probe
  always_comb begin
    stat.last_sample = (k == nlast);
    stat.use_second  = use2;
    if (!read_ok) stat.answer = ANS_NONE;
    else if ($signed(rdata) >= $signed({1'b0, thresh})) stat.answer = ANS_BLOCKED;
    else if (rdata == VAL_UNOBSERVED) stat.answer = ANS_NONE;
    else stat.answer = ANS_FREE;
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= cmd.ack || cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (cmd.ack) begin
      path_free       <= 1'b0;
      outcome         <= OUT_ACK;
      samples_checked <= '0;
    end else if (cmd.finish) begin
      path_free       <= (cmd.finish_code == OUT_FREE);
      outcome         <= cmd.finish_code;
      samples_checked <= k + 17'd1;
    end
  end

endmodule

>>> rtl/core/grid_segment_free_check.sv
`timescale 1ns / 1ps
// Occupancy grid segment check. Loads, geometry sets and unused operations
// give the result word in the cycle after start is taken. A check computes
// the squares, the square root and the two per-axis divisions, starts the
// walk and then probes the grid for each sample (one or two probes a sample,
// one memory read each); busy is high through all of these and drops in the
// following cycle, when the result word appears.
// Each result is shown for one cycle with result_valid and
// cannot be held off, so the receiver must take it when it appears.
// Configuration writes are taken only while busy is low.
module grid_segment_free_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [1:0]         slot,
  input  logic [1:0]         second_slot,
  input  logic               use_second,
  input  logic [15:0]        cell_index,
  input  logic signed [7:0]  cell_value,
  input  logic signed [23:0] point_a_x,
  input  logic signed [23:0] point_a_y,
  input  logic signed [23:0] point_b_x,
  input  logic signed [23:0] point_b_y,
  input  logic [10:0]        grid_width,
  input  logic [10:0]        grid_height,
  output logic               result_valid,
  output logic               path_free,
  output logic [1:0]         outcome,
  output logic [16:0]        samples_checked,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);
  import gsfc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = !busy;

  gsfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  gsfc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .slot            (slot),
    .second_slot     (second_slot),
    .use_second      (use_second),
    .cell_index      (cell_index),
    .cell_value      (cell_value),
    .point_a_x       (point_a_x),
    .point_a_y       (point_a_y),
    .point_b_x       (point_b_x),
    .point_b_y       (point_b_y),
    .grid_width      (grid_width),
    .grid_height     (grid_height),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .result_valid    (result_valid),
    .path_free       (path_free),
    .outcome         (outcome),
    .samples_checked (samples_checked)
  );

endmodule

>>> rtl/core/gsfc_checker.sv
`timescale 1ns / 1ps
`include "grid_segment_free_check_macros.svh"
module gsfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  operation,
  input logic        result_valid,
  input logic        path_free,
  input logic [1:0]  outcome,
  input logic        cfg_ready
);
  import gsfc_pkg::*;

  // a word other than a check is acknowledged in the next cycle
  `GSFC_ASSERT_NEXT(a_ack_next, start && !busy && operation != OP_CHECK, result_valid && outcome == OUT_ACK)
  // a check holds the block busy
  `GSFC_ASSERT_NEXT(a_check_busy, start && !busy && operation == OP_CHECK, busy && !result_valid)
  // the free flag agrees with the outcome
  `GSFC_ASSERT_NOW(a_free_flag, result_valid, path_free == (outcome == OUT_FREE))
  // a check result ends the busy period
  `GSFC_ASSERT_NOW(a_check_done, result_valid && outcome != OUT_ACK, !busy && $past(busy) && cfg_ready)

endmodule

bind grid_segment_free_check gsfc_checker u_gsfc_checker (.*);

>>> sim/tb_grid_segment_free_check.sv
`timescale 1ns / 1ps
module tb_grid_segment_free_check;
  import gsfc_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [1:0]         op;
    logic [1:0]         s;
    logic [1:0]         s2;
    logic               u2;
    logic [15:0]        idx;
    logic signed [7:0]  val;
    logic signed [23:0] ax, ay, bx, by;
    logic [10:0]        w, h;
  } word_t;

  typedef struct packed {
    logic        free;
    logic [1:0]  code;
    logic [16:0] count;
  } verdict_t;

  typedef struct {
    word_t    wd;
    bit       typed;
    verdict_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] operation = '0, slot = '0, second_slot = '0;
  logic use_second = 1'b0;
  logic [15:0] cell_index = '0;
  logic signed [7:0] cell_value = '0;
  logic signed [23:0] point_a_x = '0, point_a_y = '0, point_b_x = '0, point_b_y = '0;
  logic [10:0] grid_width = '0, grid_height = '0;
  logic result_valid, path_free;
  logic [1:0] outcome;
  logic [16:0] samples_checked;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_data = '0;

  grid_segment_free_check dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .slot(slot), .second_slot(second_slot),
    .use_second(use_second), .cell_index(cell_index), .cell_value(cell_value),
    .point_a_x(point_a_x), .point_a_y(point_a_y),
    .point_b_x(point_b_x), .point_b_y(point_b_y),
    .grid_width(grid_width), .grid_height(grid_height),
    .result_valid(result_valid), .path_free(path_free), .outcome(outcome),
    .samples_checked(samples_checked),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the grids, slot geometry and threshold
  logic [7:0]  grid_cells [NUM_SLOTS][CELLS_PER_SLOT];
  bit          cell_loaded [NUM_SLOTS][CELLS_PER_SLOT];
  bit          slot_set [NUM_SLOTS];
  longint      org_x [NUM_SLOTS], org_y [NUM_SLOTS];
  longint      span_w [NUM_SLOTS], span_h [NUM_SLOTS];
  logic [6:0]  occ_threshold = THRESH_RESET;
  bit          hit_unloaded;
  bit          quiet = 1'b0;

  verdict_t pending_verdicts [$];
  int       fail_count = 0;
  longint   cycle_count = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Cell coordinate, truncated toward zero; false when a whole cell or more left of the grid
  function automatic bit cell_coord(longint rel, output longint c);
    c = 0;
    if (rel < 0) return ((-rel) >> FRAC_BITS) == 0;
    c = rel >> FRAC_BITS;
    return 1'b1;
  endfunction

  function automatic logic [1:0] grid_answer(int s, longint px, longint py);
    longint cx, cy, addr;
    logic signed [7:0] v;
    if (!slot_set[s]) return ANS_NONE;
    if (!cell_coord(px - org_x[s], cx)) return ANS_NONE;
    if (!cell_coord(py - org_y[s], cy)) return ANS_NONE;
    if (cx >= span_w[s] || cy >= span_h[s]) return ANS_NONE;
    addr = cy * span_w[s] + cx;
    if (addr >= CELLS_PER_SLOT) return ANS_NONE;
    if (!cell_loaded[s][addr]) hit_unloaded = 1'b1;
    v = grid_cells[s][addr];
    if (int'(v) >= int'({1'b0, occ_threshold})) return ANS_BLOCKED;
    if (v == -8'sd1) return ANS_NONE;
    return ANS_FREE;
  endfunction

  function automatic longint step_offset(longint d, longint unsigned k, longint unsigned r);
    longint unsigned mag, q;
    if (r == 0 || k == 0) return 0;
    mag = (d < 0) ? longint'(-d) : d;
    q = (mag * (k << FRAC_BITS)) / r;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Walk the segment; leaves the shadow grid state alone but sets hit_unloaded
  function automatic verdict_t walk_segment(word_t wd);
    longint ax, ay, dx, dy, px, py;
    longint unsigned sq, r, n, k;
    logic [1:0] a;
    verdict_t vd;
    hit_unloaded = 1'b0;
    ax = wd.ax;
    ay = wd.ay;
    dx = longint'(wd.bx) - ax;
    dy = longint'(wd.by) - ay;
    sq = dx * dx + dy * dy;
    r = int_sqrt(sq);
    n = r >> FRAC_BITS;
    vd.free = 1'b1;
    vd.code = OUT_FREE;
    vd.count = 17'(n + 1);
    for (k = 0; k <= n; k++) begin
      px = ax + step_offset(dx, k, r);
      py = ay + step_offset(dy, k, r);
      a = grid_answer(wd.s, px, py);
      if (a == ANS_NONE && wd.u2) a = grid_answer(wd.s2, px, py);
      if (a != ANS_FREE) begin
        vd.free = 1'b0;
        vd.code = (a == ANS_BLOCKED) ? OUT_OCC : OUT_UNKNOWN;
        vd.count = 17'(k + 1);
        break;
      end
    end
    return vd;
  endfunction

  // Apply one accepted word to the shadow state and return its verdict
  function automatic verdict_t apply_word(word_t wd);
    verdict_t vd = '{free: 1'b0, code: OUT_ACK, count: '0};
    if (wd.op == OP_LOAD) begin
      grid_cells[wd.s][wd.idx] = wd.val;
      cell_loaded[wd.s][wd.idx] = 1'b1;
    end else if (wd.op == OP_GEOM) begin
      slot_set[wd.s] = 1'b1;
      org_x[wd.s] = wd.ax;
      org_y[wd.s] = wd.ay;
      span_w[wd.s] = wd.w;
      span_h[wd.s] = wd.h;
    end else if (wd.op == OP_CHECK) begin
      vd = walk_segment(wd);
    end
    return vd;
  endfunction

  // Drive one word and wait for it to be taken
  task automatic send_word(word_t wd, bit typed, verdict_t want);
    verdict_t vd;
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 35) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    operation = wd.op; slot = wd.s; second_slot = wd.s2; use_second = wd.u2;
    cell_index = wd.idx; cell_value = wd.val;
    point_a_x = wd.ax; point_a_y = wd.ay; point_b_x = wd.bx; point_b_y = wd.by;
    grid_width = wd.w; grid_height = wd.h;
    start = 1'b1;
    do @(posedge clk); while (busy);
    vd = apply_word(wd);
    pending_verdicts.insert(pending_verdicts.size(), typed ? want : vd);
  endtask

  // Hold off until every verdict is back, then write the threshold
  task automatic write_threshold(logic [6:0] v);
    @(negedge clk);
    start = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    occ_threshold = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic word_t mk(logic [1:0] op, logic [1:0] s, logic [1:0] s2, logic u2,
                               logic [15:0] idx, logic signed [7:0] val,
                               logic signed [23:0] ax, logic signed [23:0] ay,
                               logic signed [23:0] bx, logic signed [23:0] by,
                               logic [10:0] w, logic [10:0] h);
    word_t wd;
    wd.op = op; wd.s = s; wd.s2 = s2; wd.u2 = u2; wd.idx = idx; wd.val = val;
    wd.ax = ax; wd.ay = ay; wd.bx = bx; wd.by = by; wd.w = w; wd.h = h;
    return wd;
  endfunction

  function automatic row_t mk_row(word_t wd, bit typed, verdict_t want);
    row_t rw;
    rw.wd = wd;
    rw.typed = typed;
    rw.want = want;
    return rw;
  endfunction

  function automatic word_t rand_load();
    int s = $urandom_range(0, NUM_SLOTS - 1);
    longint cells = span_w[s] * span_h[s];
    longint top = (cells > 0 && slot_set[s]) ? cells - 1 : 63;
    if (top > 65535) top = 65535;
    return mk(OP_LOAD, 2'(s), 2'($urandom), 1'($urandom),
              ($urandom_range(99) < 85) ? 16'($urandom_range(0, int'(top))) : 16'($urandom),
              ($urandom_range(99) < 70) ? 8'(int'($urandom_range(0, 101)) - 1) : 8'($urandom),
              24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
              11'($urandom), 11'($urandom));
  endfunction

  function automatic word_t rand_geom();
    word_t wd;
    logic [10:0] w = 11'($urandom_range(1, 8));
    logic [10:0] h = 11'($urandom_range(1, 8));
    case ($urandom_range(0, 11))
      0: begin w = 1024; h = 1; end
      1: begin w = 1; h = 1024; end
      2: begin w = 256; h = 256; end
      3: begin w = 0; end
      4: begin h = 0; end
      5: begin w = 1024; h = 64; end
      default: ;
    endcase
    wd = mk(OP_GEOM, 2'($urandom), 2'($urandom), 1'($urandom), 16'($urandom),
            8'($urandom), 24'(int'($urandom_range(0, 4096)) - 2048),
            24'(int'($urandom_range(0, 4096)) - 2048),
            24'($urandom), 24'($urandom), w, h);
    if ($urandom_range(99) < 20) begin
      wd.ax = 24'($urandom);
      wd.ay = 24'($urandom);
    end
    return wd;
  endfunction

  // Segment mostly around a grid, sometimes anywhere at all
  function automatic word_t rand_check();
    word_t wd;
    int s = $urandom_range(0, NUM_SLOTS - 1);
    longint sw = (span_w[s] > 40) ? 40 : span_w[s];
    longint sh = (span_h[s] > 40) ? 40 : span_h[s];
    longint ox = slot_set[s] ? org_x[s] : 0;
    longint oy = slot_set[s] ? org_y[s] : 0;
    wd = mk(OP_CHECK, 2'(s), 2'($urandom), 1'($urandom), 16'($urandom), 8'($urandom),
            24'(ox + $urandom_range(0, int'((sw + 2) * 256)) - 512),
            24'(oy + $urandom_range(0, int'((sh + 2) * 256)) - 512),
            24'(ox + $urandom_range(0, int'((sw + 2) * 256)) - 512),
            24'(oy + $urandom_range(0, int'((sh + 2) * 256)) - 512),
            11'($urandom), 11'($urandom));
    if ($urandom_range(99) < 10) begin
      wd.bx = wd.ax;
      wd.by = wd.ay;
    end else if ($urandom_range(99) < 15) begin
      wd.ax = 24'($urandom); wd.ay = 24'($urandom);
      wd.bx = 24'($urandom); wd.by = 24'($urandom);
    end
    return wd;
  endfunction

  // Compare each result word with the oldest verdict waiting
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && result_valid) begin
      if (pending_verdicts.size() == 0) begin
        $error("result word with no verdict waiting");
        fail_count++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (path_free !== exp_v.free) begin
          $error("path_free expected %0d got %0d", exp_v.free, path_free);
          fail_count++;
        end
        if (outcome !== exp_v.code) begin
          $error("outcome expected %0d got %0d", exp_v.code, outcome);
          fail_count++;
        end
        if (samples_checked !== exp_v.count) begin
          $error("samples_checked expected %0d got %0d", exp_v.count, samples_checked);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("grid_segment_free_check verification failed");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    word_t wd;
    verdict_t none_v;
    verdict_t ack_v;
    logic [6:0] levels [6];
    int tries;
    int sel;
    none_v = '{free: 1'b0, code: OUT_UNKNOWN, count: 17'd1};
    ack_v = '{free: 1'b0, code: OUT_ACK, count: '0};
    levels = '{7'd0, 7'd101, 7'd1, 7'd26, 7'($urandom_range(0, 101)), THRESH_RESET};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words: empty slots, each cell kind, extremes of the fields
    rows = {rows, mk_row(mk(OP_CHECK, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1, none_v)};
    rows = {rows, mk_row(mk(OP_GEOM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4, 1), 1, ack_v)};
    rows = {rows, mk_row(mk(OP_GEOM, 1, 0, 0, 0, 0, 0, 0, 0, 0, 4, 1), 1, ack_v)};
    rows = {rows, mk_row(mk(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ack_v)};
    rows = {rows, mk_row(mk(OP_LOAD, 0, 0, 0, 1, -1, 0, 0, 0, 0, 0, 0), 1, ack_v)};
    rows = {rows, mk_row(mk(OP_LOAD, 0, 0, 0, 2, 100, 0, 0, 0, 0, 0, 0), 1, ack_v)};
    rows = {rows, mk_row(mk(OP_LOAD, 0, 0, 0, 3, -128, 0, 0, 0, 0, 0, 0), 1, ack_v)};
    rows = {rows, mk_row(mk(OP_LOAD, 1, 0, 0, 1, 5, 0, 0, 0, 0, 0, 0), 1, ack_v)};
    rows = {rows, mk_row(mk(OP_LOAD, 3, 0, 0, 16'hFFFF, 127, 0, 0, 0, 0, 0, 0), 1, ack_v)};
    rows = {rows, mk_row(mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{free: 1'b1, code: OUT_FREE, count: 17'd1})};
    rows = {rows, mk_row(mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 896, 0, 0, 0), 0, ack_v)};
    rows = {rows, mk_row(mk(OP_CHECK, 0, 1, 1, 0, 0, 0, 0, 896, 0, 0, 0), 0, ack_v)};
    rows = {rows, mk_row(mk(OP_CHECK, 0, 0, 0, 0, 0, 768, 0, 768, 0, 0, 0), 0, ack_v)};
    rows = {rows, mk_row(mk(OP_CHECK, 0, 0, 0, 0, 0, 1024, 0, 1024, 0, 0, 0), 0, ack_v)};
    rows = {rows, mk_row(mk(OP_CHECK, 0, 0, 0, 0, 0, -100, -100, -100, -100, 0, 0), 0,
                         ack_v)};
    rows = {rows, mk_row(mk(OP_CHECK, 0, 1, 1, 0, 0, 24'sh800000, 24'sh800000,
                            24'sh7FFFFF, 24'sh7FFFFF, 0, 0), 1, none_v)};
    rows = {rows, mk_row(mk(OP_CHECK, 3, 2, 1, 0, 0, 24'sh7FFFFF, 24'sh800000,
                            24'sh800000, 24'sh7FFFFF, 0, 0), 1, none_v)};
    rows = {rows, mk_row(mk(OP_GEOM, 3, 0, 0, 0, 0, 24'sh7FFFFF, 24'sh800000, 0, 0,
                            1024, 64), 1, ack_v)};
    rows = {rows, mk_row(mk(OP_GEOM, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1024), 1, ack_v)};
    rows = {rows, mk_row(mk(OP_CHECK, 2, 0, 1, 0, 0, 0, 0, 512, 0, 0, 0), 0, ack_v)};
    foreach (rows[i]) send_word(rows[i].wd, rows[i].typed, rows[i].want);

    // Give every slot a small grid and load all of its first cells
    for (int s = 0; s < NUM_SLOTS; s++) begin
      wd = rand_geom();
      wd.s = 2'(s);
      wd.w = 11'($urandom_range(1, 8));
      wd.h = 11'($urandom_range(1, 8));
      send_word(wd, 0, ack_v);
      for (int i = 0; i < 64; i++) begin
        wd = rand_load();
        wd.s = 2'(s);
        wd.idx = 16'(i);
        send_word(wd, 0, ack_v);
      end
    end

    // Random phases, one per threshold setting
    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(levels[ph]);
      quiet = (ph == 2);
      for (int i = 0; i < 240; i++) begin
        sel = $urandom_range(99);
        if (sel < 15) begin
          wd = rand_load();
        end else if (sel < 22) begin
          wd = rand_geom();
        end else begin
          tries = 0;
          do begin
            wd = rand_check();
            void'(walk_segment(wd));
            tries++;
          end while (hit_unloaded && tries < 30);
          if (hit_unloaded) wd = rand_load();
        end
        send_word(wd, 0, ack_v);
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("grid_segment_free_check verification clean");
    end else begin
      $display("grid_segment_free_check verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/gsfc_pkg.sv
rtl/core/gsfc_ctrl.sv
rtl/core/gsfc_dp.sv
rtl/core/grid_segment_free_check.sv
rtl/core/gsfc_checker.sv
sim/tb_grid_segment_free_check.sv
